// File: hdl/tts_pkg.sv
// Shared constants, register indexes and types of the text screen writer.
`timescale 1ns / 1ps

package tts_pkg;

    localparam int COLS_MAX_DEF  = 128;
    localparam int LINES_MAX_DEF = 64;
    localparam int TAB_STOP_DEF  = 8;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 8;

    localparam logic [CFG_AW-1:0] REG_MAX_COLS    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_LINES   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LF_ON_CR    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CR_ON_LF    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_WRAP_ENABLE = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CHAR_MASK   = 3'd5;

    localparam logic [7:0] RST_MAX_COLS  = 8'd80;
    localparam logic [6:0] RST_MAX_LINES = 7'd25;
    localparam logic [7:0] RST_CHAR_MASK = 8'hFF;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_HT  = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [7:0] max_cols;
        logic [6:0] max_lines;
        logic       lf_on_cr;
        logic       cr_on_lf;
        logic       wrap_enable;
        logic [7:0] char_mask;
    } t_cfg;

endpackage

// File: hdl/tts_ifs.sv
// Valid/ready channel interfaces for items, results and register writes.
`timescale 1ns / 1ps

interface tts_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_in;
    logic [5:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, cmd, char_in, read_row, read_col, input ready);
    modport sink   (input valid, cmd, char_in, read_row, read_col, output ready);
endinterface

interface tts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_data;
    logic [7:0] cursor_col;
    logic [5:0] current_row;
    logic       bell;
    logic       scrolled;

    modport source (output valid, cell_data, cursor_col, current_row, bell, scrolled,
                    input ready);
    modport sink   (input valid, cell_data, cursor_col, current_row, bell, scrolled,
                    output ready);
endinterface

interface tts_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] addr;
    logic [7:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: hdl/tts_cfg_regs.sv
// Configuration register file of the text screen writer.
`timescale 1ns / 1ps

module tts_cfg_regs
    import tts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tts_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_cols    <= RST_MAX_COLS;
            r_cfg.max_lines   <= RST_MAX_LINES;
            r_cfg.lf_on_cr    <= 1'b0;
            r_cfg.cr_on_lf    <= 1'b0;
            r_cfg.wrap_enable <= 1'b1;
            r_cfg.char_mask   <= RST_CHAR_MASK;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                REG_MAX_COLS:    r_cfg.max_cols    <= i_cfg.data;
                REG_MAX_LINES:   r_cfg.max_lines   <= i_cfg.data[6:0];
                REG_LF_ON_CR:    r_cfg.lf_on_cr    <= i_cfg.data[0];
                REG_CR_ON_LF:    r_cfg.cr_on_lf    <= i_cfg.data[0];
                REG_WRAP_ENABLE: r_cfg.wrap_enable <= i_cfg.data[0];
                REG_CHAR_MASK:   r_cfg.char_mask   <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/tts_cell_mem.sv
// Character cell memory with a clearing pass after reset.
`timescale 1ns / 1ps

module tts_cell_mem
    import tts_pkg::*;
#(
    parameter int AW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata,
    output logic          o_busy
);

    logic [7:0]    r_mem [2**AW];
    logic [7:0]    r_rdata;
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;
    logic          wen;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    assign wen     = r_busy | i_we;
    assign waddr   = r_busy ? r_clr_addr : i_waddr;
    assign wdata   = r_busy ? CH_NUL : i_wdata;
    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/tts_ctrl.sv
// Command sequencer: cursor, ring row, line clearing, tabs and the result register.
`timescale 1ns / 1ps

module tts_ctrl
    import tts_pkg::*;
#(
    parameter int COLS_MAX  = COLS_MAX_DEF,
    parameter int LINES_MAX = LINES_MAX_DEF,
    parameter int TAB_STOP  = TAB_STOP_DEF,
    parameter int CW        = $clog2(COLS_MAX),
    parameter int RW        = $clog2(LINES_MAX)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tts_in_if.sink           i_in,
    tts_out_if.source        o_out,
    input  t_cfg             i_cfg,
    input  logic             i_mem_busy,
    input  logic [7:0]       i_mem_rdata,
    output logic             o_mem_we,
    output logic [RW+CW-1:0] o_mem_waddr,
    output logic [7:0]       o_mem_wdata,
    output logic [RW+CW-1:0] o_mem_raddr
);

    localparam int CCW = $clog2(COLS_MAX + 1);
    localparam int LW  = $clog2(LINES_MAX + 1);
    localparam int PW  = $clog2(TAB_STOP);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_LF    = 3'd2;
    localparam logic [2:0] ST_HT_RD = 3'd3;
    localparam logic [2:0] ST_HT_WR = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]     r_state, n_state;
    logic [CCW-1:0] r_cursor, n_cursor;
    logic [PW-1:0]  r_phase, n_phase;
    logic [RW-1:0]  r_row, n_row;
    logic [CCW-1:0] r_idx, n_idx;
    logic [CCW-1:0] r_keep, n_keep;
    logic [7:0]     r_cell, n_cell;
    logic           r_bell, n_bell;
    logic           r_scr, n_scr;
    logic           r_rd_ok, n_rd_ok;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_o_cell, n_o_cell;
    logic [7:0]     r_o_cursor, n_o_cursor;
    logic [5:0]     r_o_row, n_o_row;
    logic           r_o_bell, n_o_bell;
    logic           r_o_scr, n_o_scr;

    logic [CCW-1:0] cols;
    logic [LW-1:0]  lines;
    logic [7:0]     ch;
    logic           in_acc;
    logic           rd_in_range;
    logic [CCW-1:0] cur_inc;
    logic [CCW-1:0] idx_inc;
    logic [PW-1:0]  ph_inc;
    logic [PW-1:0]  ph_dec;
    logic [LW-1:0]  row_inc;
    logic [RW-1:0]  row_next;
    logic           ht_skip;
    logic [CCW-1:0] lf_cur;

    assign cols = (i_cfg.max_cols == 8'd0) ? CCW'(1)
                : (int'(i_cfg.max_cols) > COLS_MAX) ? CCW'(COLS_MAX)
                : CCW'(i_cfg.max_cols);
    assign lines = (i_cfg.max_lines == 7'd0) ? LW'(1)
                 : (int'(i_cfg.max_lines) > LINES_MAX) ? LW'(LINES_MAX)
                 : LW'(i_cfg.max_lines);

    assign ch          = i_in.char_in & i_cfg.char_mask;
    assign i_in.ready  = (r_state == ST_IDLE) && !i_mem_busy;
    assign in_acc      = i_in.valid && i_in.ready;
    assign rd_in_range = (int'(i_in.read_row) < LINES_MAX) && (int'(i_in.read_col) < COLS_MAX);

    assign cur_inc  = r_cursor + CCW'(1);
    assign idx_inc  = r_idx + CCW'(1);
    assign ph_inc   = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
    assign ph_dec   = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
    assign row_inc  = LW'(r_row) + LW'(1);
    assign row_next = (row_inc >= lines) ? '0 : RW'(row_inc);
    assign ht_skip  = ({1'b0, r_cursor} + (CCW+1)'(1)) >= {1'b0, cols};
    assign lf_cur   = i_cfg.cr_on_lf ? '0 : r_cursor;

    assign o_mem_raddr = (r_state == ST_IDLE)
                       ? {RW'(i_in.read_row), CW'(i_in.read_col)}
                       : {r_row, r_cursor[CW-1:0]};

    assign o_out.valid       = r_out_valid;
    assign o_out.cell_data   = r_o_cell;
    assign o_out.cursor_col  = r_o_cursor;
    assign o_out.current_row = r_o_row;
    assign o_out.bell        = r_o_bell;
    assign o_out.scrolled    = r_o_scr;

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_phase     = r_phase;
        n_row       = r_row;
        n_idx       = r_idx;
        n_keep      = r_keep;
        n_cell      = r_cell;
        n_bell      = r_bell;
        n_scr       = r_scr;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_cell    = r_o_cell;
        n_o_cursor  = r_o_cursor;
        n_o_row     = r_o_row;
        n_o_bell    = r_o_bell;
        n_o_scr     = r_o_scr;
        o_mem_we    = 1'b0;
        o_mem_waddr = {r_row, r_cursor[CW-1:0]};
        o_mem_wdata = ch;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cell = 8'd0;
                    n_bell = 1'b0;
                    n_scr  = 1'b0;
                    if (i_in.cmd) begin
                        n_rd_ok = rd_in_range;
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_DONE;
                        if (ch >= CH_SP) begin
                            if (r_cursor < cols) begin
                                o_mem_we = 1'b1;
                                n_cursor = cur_inc;
                                n_phase  = ph_inc;
                                if (cur_inc >= cols && i_cfg.wrap_enable) begin
                                    n_cursor = '0;
                                    n_phase  = '0;
                                    n_keep   = '0;
                                    n_idx    = '0;
                                    n_row    = row_next;
                                    n_scr    = 1'b1;
                                    n_state  = ST_LF;
                                end
                            end
                        end else begin
                            unique case (ch)
                                CH_BEL: n_bell = 1'b1;
                                CH_HT: begin
                                    if (!ht_skip) begin
                                        n_state = ST_HT_RD;
                                    end
                                end
                                CH_CR: begin
                                    n_cursor = '0;
                                    n_phase  = '0;
                                    if (i_cfg.lf_on_cr) begin
                                        n_keep  = '0;
                                        n_idx   = '0;
                                        n_row   = row_next;
                                        n_scr   = 1'b1;
                                        n_state = ST_LF;
                                    end
                                end
                                CH_LF: begin
                                    if (i_cfg.cr_on_lf) begin
                                        n_cursor = '0;
                                        n_phase  = '0;
                                    end
                                    n_keep  = (lf_cur < cols) ? lf_cur : cols;
                                    n_idx   = '0;
                                    n_row   = row_next;
                                    n_scr   = 1'b1;
                                    n_state = ST_LF;
                                end
                                CH_BS: begin
                                    if (r_cursor != '0) begin
                                        n_cursor = r_cursor - CCW'(1);
                                        n_phase  = ph_dec;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            ST_RD: begin
                n_cell  = r_rd_ok ? i_mem_rdata : 8'd0;
                n_state = ST_DONE;
            end
            ST_LF: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = {r_row, r_idx[CW-1:0]};
                o_mem_wdata = (r_idx < r_keep) ? CH_SP : CH_NUL;
                n_idx       = idx_inc;
                if (idx_inc >= cols) begin
                    n_state = ST_DONE;
                end
            end
            ST_HT_RD: begin
                n_state = ST_HT_WR;
            end
            ST_HT_WR: begin
                o_mem_we    = (i_mem_rdata == CH_NUL);
                o_mem_wdata = CH_SP;
                n_cursor    = cur_inc;
                n_phase     = ph_inc;
                if (ph_inc != '0 && ({1'b0, cur_inc} + (CCW+1)'(1)) < {1'b0, cols}) begin
                    n_state = ST_HT_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_cell    = r_cell;
                    n_o_cursor  = 8'(r_cursor);
                    n_o_row     = 6'(r_row);
                    n_o_bell    = r_bell;
                    n_o_scr     = r_scr;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_phase     <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_phase     <= n_phase;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_keep     <= n_keep;
        r_cell     <= n_cell;
        r_bell     <= n_bell;
        r_scr      <= n_scr;
        r_rd_ok    <= n_rd_ok;
        r_o_cell   <= n_o_cell;
        r_o_cursor <= n_o_cursor;
        r_o_row    <= n_o_row;
        r_o_bell   <= n_o_bell;
        r_o_scr    <= n_o_scr;
    end

    // The clearing pass owns the memory; no item may write into it meanwhile.
    a_no_write_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> !i_mem_busy)
        else $error("cell write during clearing pass");

    a_lf_index_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LF) |-> (r_idx < cols))
        else $error("line clear index beyond line");

    a_tab_inside_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HT_WR) |-> (({1'b0, r_cursor} + (CCW+1)'(1)) < {1'b0, cols}))
        else $error("tab cursor reached last column");

    a_read_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> ($past(r_state) == ST_IDLE && $past(in_acc)))
        else $error("read state without accepted item");

endmodule

// File: hdl/tty_text_screen_writer.sv
// Top level of the text screen writer: registers, cell memory and sequencer.
//
//  Channel  Direction  Handshake          Contents
//  i_in     sink       valid/ready        cmd, char_in, read_row, read_col
//  o_out    source     valid/ready        cell_data, cursor_col, current_row, bell, scrolled
//  i_cfg    sink       valid/ready (=1)   addr (register index), data
//
// A printable or other single-step item passes IDLE and DONE, a read IDLE, RD and DONE, a
// line feed (also one caused by wrap or CR) IDLE, LF per cell of the line and DONE, and a
// tab IDLE, HT_RD and HT_WR per cell walked, then DONE, since the cell memory gives one
// write per cycle and registered read data. After reset a clearing pass writes NUL to all
// 2**(RW+CW) cells, 8192 at the default sizes, while i_in.ready stays low. A held result
// in o_out only stalls the sequencer when the next result is ready to be loaded.
`timescale 1ns / 1ps

module tty_text_screen_writer
    import tts_pkg::*;
#(
    parameter int COLS_MAX  = COLS_MAX_DEF,
    parameter int LINES_MAX = LINES_MAX_DEF,
    parameter int TAB_STOP  = TAB_STOP_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tts_in_if.sink    i_in,
    tts_out_if.source o_out,
    tts_cfg_if.sink   i_cfg
);

    localparam int CW = $clog2(COLS_MAX);
    localparam int RW = $clog2(LINES_MAX);
    localparam int AW = RW + CW;

    t_cfg          cfg;
    logic          mem_busy;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    tts_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tts_cell_mem #(
        .AW (AW)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    tts_ctrl #(
        .COLS_MAX  (COLS_MAX),
        .LINES_MAX (LINES_MAX),
        .TAB_STOP  (TAB_STOP),
        .CW        (CW),
        .RW        (RW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg       (cfg),
        .i_mem_busy  (mem_busy),
        .i_mem_rdata (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr)
    );

endmodule

// File: bench/tb.sv
// Self-checking testbench for the text screen writer with a built-in screen predictor.
`timescale 1ns / 1ps

module tb;
    import tts_pkg::*;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int CLK_HALF         = 5;
    localparam int SETTLE_CYCLES    = 2 * COLS_MAX_DEF + 16;
    localparam int WATCHDOG_LIMIT   = 50000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 1500;
    localparam int RANDOM_PHASES    = 12;
    localparam int PRESSURE_ITEMS   = 40;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_in;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } t_tty_item;

    typedef struct packed {
        logic [7:0] cell_data;
        logic [7:0] cursor_col;
        logic [5:0] current_row;
        logic       bell;
        logic       scrolled;
    } t_screen_result;

    logic i_clk;
    logic i_rst_n;

    tts_in_if  in_ch ();
    tts_out_if out_ch ();
    tts_cfg_if cfg_ch ();

    tty_text_screen_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_cfg        shadow_cfg;
    logic [7:0]  screen_mem [0:LINES_MAX_DEF-1][0:COLS_MAX_DEF-1];
    int unsigned cursor_pos;
    int unsigned ring_pos;
    bit          item_ignored;

    t_screen_result screen_results_q [$];

    int  error_count;
    int  items_sent;
    int  useful_items;
    int  reads_sent;
    int  feeds_seen;
    int  bells_seen;
    int  results_checked;
    int  settings_applied;
    int  idle_cycles;
    int  hold_left;
    bit  long_hold_req;
    bit  tx_gaps_on;
    bit  rx_stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int unsigned cols_in_use();
        if (shadow_cfg.max_cols < 1) return 1;
        if (shadow_cfg.max_cols > COLS_MAX_DEF) return COLS_MAX_DEF;
        return shadow_cfg.max_cols;
    endfunction

    function automatic int unsigned lines_in_use();
        if (shadow_cfg.max_lines < 1) return 1;
        if (shadow_cfg.max_lines > LINES_MAX_DEF) return LINES_MAX_DEF;
        return shadow_cfg.max_lines;
    endfunction

    // Moves to the next ring row and blanks it: spaces under the old cursor, NUL beyond.
    function automatic void advance_line();
        int unsigned cols;
        int unsigned keep;
        int unsigned i;
        cols = cols_in_use();
        ring_pos++;
        if (ring_pos > lines_in_use() - 1) ring_pos = 0;
        keep = (cursor_pos < cols) ? cursor_pos : cols;
        for (i = 0; i < cols; i++) begin
            screen_mem[ring_pos][i] = (i < keep) ? CH_SP : CH_NUL;
        end
    endfunction

    function automatic void tab_forward();
        int unsigned cols;
        cols = cols_in_use();
        if (cursor_pos + 1 >= cols) begin
            item_ignored = 1'b1;
            return;
        end
        do begin
            if (screen_mem[ring_pos][cursor_pos] == CH_NUL) screen_mem[ring_pos][cursor_pos] = CH_SP;
            cursor_pos++;
        end while ((cursor_pos % TAB_STOP_DEF) != 0 && cursor_pos + 1 < cols);
    endfunction

    function automatic t_screen_result predict_screen(t_tty_item it);
        t_screen_result r;
        logic [7:0]     ch;
        int unsigned    cols;
        r = '0;
        item_ignored = 1'b0;
        if (it.cmd == CMD_READ) begin
            r.cell_data = screen_mem[it.read_row][it.read_col];
        end else begin
            ch = it.char_in & shadow_cfg.char_mask;
            cols = cols_in_use();
            if (ch >= CH_SP) begin
                if (cursor_pos < cols) begin
                    screen_mem[ring_pos][cursor_pos] = ch;
                    cursor_pos++;
                    if (cursor_pos >= cols && shadow_cfg.wrap_enable) begin
                        cursor_pos = 0;
                        advance_line();
                        r.scrolled = 1'b1;
                    end
                end else begin
                    item_ignored = 1'b1;
                end
            end else begin
                case (ch)
                    CH_BEL: r.bell = 1'b1;
                    CH_HT:  tab_forward();
                    CH_CR: begin
                        cursor_pos = 0;
                        if (shadow_cfg.lf_on_cr) begin
                            advance_line();
                            r.scrolled = 1'b1;
                        end
                    end
                    CH_LF: begin
                        if (shadow_cfg.cr_on_lf) cursor_pos = 0;
                        advance_line();
                        r.scrolled = 1'b1;
                    end
                    CH_BS: begin
                        if (cursor_pos > 0) cursor_pos--;
                        else item_ignored = 1'b1;
                    end
                    default: item_ignored = 1'b1;
                endcase
            end
        end
        r.cursor_col  = 8'(cursor_pos);
        r.current_row = 6'(ring_pos);
        return r;
    endfunction

    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_tty_item put_item(logic [7:0] ch);
        t_tty_item it;
        it.cmd      = CMD_PUT;
        it.char_in  = ch;
        it.read_row = 6'($urandom_range(0, 63));
        it.read_col = 7'($urandom_range(0, 127));
        return it;
    endfunction

    function automatic t_tty_item read_item(logic [5:0] row, logic [6:0] col);
        t_tty_item it;
        it.cmd      = CMD_READ;
        it.char_in  = 8'($urandom_range(0, 255));
        it.read_row = row;
        it.read_col = col;
        return it;
    endfunction

    function automatic t_cfg make_settings(logic [7:0] cols, logic [6:0] lines, logic lfcr,
                                           logic crlf, logic wrap, logic [7:0] mask);
        t_cfg c;
        c.max_cols    = cols;
        c.max_lines   = lines;
        c.lf_on_cr    = lfcr;
        c.cr_on_lf    = crlf;
        c.wrap_enable = wrap;
        c.char_mask   = mask;
        return c;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(input t_tty_item it);
        int             gap;
        t_screen_result want;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 9) < 4) gap = pick_gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= it.cmd;
        in_ch.char_in  <= it.char_in;
        in_ch.read_row <= it.read_row;
        in_ch.read_col <= it.read_col;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        want = predict_screen(it);
        screen_results_q.push_back(want);
        items_sent++;
        if (it.cmd == CMD_READ) reads_sent++;
        if (want.scrolled) feeds_seen++;
        if (want.bell) bells_seen++;
        if (!item_ignored) useful_items++;
    endtask

    task automatic wait_until_idle();
        in_ch.valid <= 1'b0;
        while (screen_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (addr)
            REG_MAX_COLS:    shadow_cfg.max_cols    = data;
            REG_MAX_LINES:   shadow_cfg.max_lines   = data[6:0];
            REG_LF_ON_CR:    shadow_cfg.lf_on_cr    = data[0];
            REG_CR_ON_LF:    shadow_cfg.cr_on_lf    = data[0];
            REG_WRAP_ENABLE: shadow_cfg.wrap_enable = data[0];
            REG_CHAR_MASK:   shadow_cfg.char_mask   = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        wait_until_idle();
        write_reg(REG_MAX_COLS, c.max_cols);
        write_reg(REG_MAX_LINES, {1'b0, c.max_lines});
        write_reg(REG_LF_ON_CR, {7'd0, c.lf_on_cr});
        write_reg(REG_CR_ON_LF, {7'd0, c.cr_on_lf});
        write_reg(REG_WRAP_ENABLE, {7'd0, c.wrap_enable});
        write_reg(REG_CHAR_MASK, c.char_mask);
        settings_applied++;
    endtask

    function automatic t_cfg pick_settings();
        int         k;
        logic [7:0] cols;
        logic [6:0] lines;
        logic [7:0] mask;
        k = $urandom_range(0, 19);
        if (k < 12)       cols = 8'($urandom_range(1, 24));
        else if (k < 16)  cols = 8'($urandom_range(25, 128));
        else if (k == 16) cols = 8'd0;
        else if (k == 17) cols = 8'($urandom_range(129, 255));
        else if (k == 18) cols = 8'd128;
        else              cols = 8'd1;
        k = $urandom_range(0, 19);
        if (k < 10)       lines = 7'($urandom_range(1, 6));
        else if (k < 16)  lines = 7'($urandom_range(7, 64));
        else if (k == 16) lines = 7'd0;
        else if (k == 17) lines = 7'($urandom_range(65, 127));
        else if (k == 18) lines = 7'd64;
        else              lines = 7'd1;
        k = $urandom_range(0, 9);
        if (k < 6)       mask = 8'hFF;
        else if (k == 6) mask = 8'($urandom_range(0, 255));
        else if (k == 7) mask = 8'h7F;
        else if (k == 8) mask = 8'h0F;
        else             mask = 8'hDF;
        return make_settings(cols, lines, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), mask);
    endfunction

    // One burst of terminal traffic: mostly text and line ends, some reads of recent and random lines.
    task automatic send_random_sequence();
        int          kind;
        int          n;
        int          i;
        int unsigned row;
        t_tty_item   it;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            n = $urandom_range(1, cols_in_use() + 3);
            if (n > 48) n = 48;
            for (i = 0; i < n; i++) send_item(put_item(8'($urandom_range(CH_SP, 255))));
        end else if (kind < 60) begin
            case ($urandom_range(0, 2))
                0: send_item(put_item(CH_CR));
                1: send_item(put_item(CH_LF));
                default: begin
                    send_item(put_item(CH_CR));
                    send_item(put_item(CH_LF));
                end
            endcase
        end else if (kind < 70) begin
            send_item(put_item(CH_HT));
            if ($urandom_range(0, 1)) send_item(put_item(8'($urandom_range(CH_SP, 255))));
            send_item(put_item(CH_HT));
        end else if (kind < 75) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_item(put_item(CH_BS));
        end else if (kind < 78) begin
            send_item(put_item(CH_BEL));
        end else if (kind < 93) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0: row = ring_pos;
                    1: row = (ring_pos == 0) ? lines_in_use() - 1 : ring_pos - 1;
                    2: row = $urandom_range(0, lines_in_use() - 1);
                    default: row = $urandom_range(0, 63);
                endcase
                if ($urandom_range(0, 3) != 0)
                    send_item(read_item(6'(row), 7'($urandom_range(0, cols_in_use() - 1))));
                else
                    send_item(read_item(6'(row), 7'($urandom_range(0, 127))));
            end
        end else begin
            it.cmd      = 1'($urandom_range(0, 1));
            it.char_in  = 8'($urandom_range(0, 255));
            it.read_row = 6'($urandom_range(0, 63));
            it.read_col = 7'($urandom_range(0, 127));
            send_item(it);
        end
    endtask

    task automatic test_controls();
        send_item(read_item(6'd0, 7'd0));
        send_item(put_item(8'h41));
        send_item(put_item(8'hFF));
        send_item(put_item(CH_SP));
        send_item(put_item(CH_BEL));
        send_item(put_item(CH_HT));
        send_item(put_item(CH_BS));
        send_item(put_item(CH_CR));
        send_item(put_item(CH_BS));
        send_item(put_item(CH_NUL));
        send_item(put_item(8'h1F));
        send_item(put_item(CH_LF));
        send_item(read_item(6'd0, 7'd0));
        send_item(read_item(6'd63, 7'd127));
    endtask

    task automatic test_line_limits();
        apply_settings(make_settings(8'd0, 7'd0, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_item(put_item(8'h78));
        send_item(put_item(CH_CR));
        apply_settings(make_settings(8'd255, 7'd127, 1'b0, 1'b0, 1'b0, 8'h0F));
        send_item(put_item(8'h4A));
        send_item(put_item(8'h47));
        apply_settings(make_settings(8'd2, 7'd64, 1'b0, 1'b0, 1'b0, 8'hFF));
        send_item(put_item(8'h61));
        send_item(put_item(8'h62));
        send_item(put_item(8'h63));
        send_item(put_item(CH_HT));
        send_item(put_item(CH_BS));
        send_item(put_item(8'h64));
        apply_settings(make_settings(8'd1, 7'd64, 1'b0, 1'b0, 1'b1, 8'hFF));
        send_item(put_item(8'h65));
        send_item(put_item(CH_LF));
    endtask

    task automatic test_random_traffic();
        int phase;
        int target;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                apply_settings(make_settings(8'd128, 7'd64, 1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)), 1'b1, 8'hFF));
            else
                apply_settings(pick_settings());
            tx_gaps_on   = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < target) send_random_sequence();
        end
    endtask

    task automatic test_backpressure();
        int i;
        apply_settings(make_settings(8'd16, 7'd4, 1'b0, 1'b0, 1'b1, 8'hFF));
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        long_hold_req = 1'b1;
        for (i = 0; i < PRESSURE_ITEMS; i++) begin
            if (i % 5 == 4)
                send_item(read_item(6'(ring_pos), 7'($urandom_range(0, 15))));
            else
                send_item(put_item(8'($urandom_range(CH_SP, 255))));
        end
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
                hold_left = pick_gap_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_checker
        t_screen_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (screen_results_q.size() == 0) begin
                $display("%0t ns: result with no item pending, cursor_col %0h row %0h",
                         $time, out_ch.cursor_col, out_ch.current_row);
                error_count++;
            end else begin
                want = screen_results_q.pop_front();
                compare_field("cell_data", want.cell_data, out_ch.cell_data);
                compare_field("cursor_col", want.cursor_col, out_ch.cursor_col);
                compare_field("current_row", 8'(want.current_row), 8'(out_ch.current_row));
                compare_field("bell", 8'(want.bell), 8'(out_ch.bell));
                compare_field("scrolled", 8'(want.scrolled), 8'(out_ch.scrolled));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, screen_results_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int c;
        in_ch.valid    <= 1'b0;
        in_ch.cmd      <= CMD_PUT;
        in_ch.char_in  <= CH_NUL;
        in_ch.read_row <= '0;
        in_ch.read_col <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.addr    <= REG_MAX_COLS;
        cfg_ch.data    <= '0;
        i_rst_n        <= 1'b0;
        tx_gaps_on     = 1'b0;
        rx_stalls_on   = 1'b0;
        long_hold_req  = 1'b0;
        hold_left      = 0;
        idle_cycles    = 0;
        shadow_cfg = make_settings(RST_MAX_COLS, RST_MAX_LINES, 1'b0, 1'b0, 1'b1, RST_CHAR_MASK);
        for (r = 0; r < LINES_MAX_DEF; r++)
            for (c = 0; c < COLS_MAX_DEF; c++) screen_mem[r][c] = CH_NUL;
        cursor_pos = 0;
        ring_pos   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_controls();
        test_line_limits();
        test_random_traffic();
        test_backpressure();
        wait_until_idle();

        $display("Sent %0d items (%0d reads, %0d line feeds, %0d bells) over %0d register settings.",
                 items_sent, reads_sent, feeds_seen, bells_seen, settings_applied);
        $display("Checked %0d results (%0d items took effect), with a %0d-cycle receiver hold.",
                 results_checked, useful_items, LONG_HOLD_CYCLES);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/tts_pkg.sv
hdl/tts_ifs.sv
hdl/tts_cfg_regs.sv
hdl/tts_cell_mem.sv
hdl/tts_ctrl.sv
hdl/tty_text_screen_writer.sv
bench/tb.sv
